/* hw/rtl/ctjm_pkg.sv */
// ----------------------------------------------------------------------------
// ctjm_pkg
// Shared types and constants of the clock TIE jitter meter.
// ----------------------------------------------------------------------------
package ctjm_pkg;

  localparam int SampleW = 16;
  localparam int FracW   = 16;
  localparam int TimeW   = 48;
  localparam int CntW    = 32;
  localparam int PerW    = 32;
  localparam int NumW    = SampleW + 1;
  localparam int QuoW    = NumW + FracW;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = 2;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_PERIOD    = 1'b1;

  typedef enum logic [1:0] {
    KIND_REF  = 2'd0,
    KIND_FALL = 2'd1,
    KIND_RISE = 2'd2
  } xkind_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      restart;
  } in_item_t;

  typedef struct packed {
    logic signed [TimeW-1:0] neg_tie;
    logic signed [TimeW-1:0] pos_tie;
    logic [TimeW-1:0]        neg_pp;
    logic [TimeW-1:0]        pos_pp;
    logic [CntW-1:0]         period_index;
  } out_item_t;

  // Crossing request from the front to the back.
  typedef struct packed {
    xkind_t          kind;
    logic [NumW-1:0] num;
    logic [NumW-1:0] den;
    logic [CntW-1:0] base;
    logic [PerW-1:0] period;
  } xreq_t;

endpackage

/* hw/rtl/clock_tie_jitter_meter.sv */
// ----------------------------------------------------------------------------
// clock_tie_jitter_meter
// Time interval error jitter meter for a sampled clock waveform.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_push / in_full  | in_item  (sample, restart)
//   out     | output    | out_pop / out_empty| out_item (TIEs, p-p, index)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Samples are taken one per cycle while no crossing is pending beyond the
// queue. Each crossing passes the bit-serial divider of the back end;
// a completed period then passes the error and peak-to-peak states.
// A restart sample waits until the back end and queue are drained.
// Reset is synchronous, active low; a full result queue stalls the back end.
// ----------------------------------------------------------------------------
module clock_tie_jitter_meter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  ctjm_pkg::in_item_t            in_item,
  output logic                          out_empty,
  input  logic                          out_pop,
  output ctjm_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [ctjm_pkg::PerW-1:0]     cfg_data
);
  import ctjm_pkg::*;

  logic signed [SampleW-1:0] thr_r;
  logic [PerW-1:0]           per_r;
  logic                      take, fr_valid, fr_restart, q_ne, q_full, pop;
  logic                      b_valid, b_ok, b_idle;
  xreq_t                     fr_req, q_req;
  out_item_t                 b_res;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full || (in_item.restart && (q_ne || !b_idle));
  assign take      = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      per_r <= PerW'(655360);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r <= cfg_data[SampleW-1:0];
        CFG_PERIOD:    per_r <= cfg_data;
        default:       per_r <= per_r;
      endcase
    end
  end

  ctjm_front u_front (
    .clk, .rst_n, .take, .item(in_item), .threshold(thr_r), .period(per_r),
    .req_valid(fr_valid), .req(fr_req), .req_restart(fr_restart)
  );

  ctjm_queue u_queue (
    .clk, .rst_n, .wr(fr_valid), .wdata(fr_req), .rd(pop),
    .rdata(q_req), .nonempty(q_ne), .full(q_full)
  );

  ctjm_back u_back (
    .clk, .rst_n, .clear(fr_restart), .req_valid(q_ne), .req(q_req),
    .req_pop(pop), .res_valid(b_valid), .res(b_res), .res_ready(b_ok),
    .idle(b_idle)
  );

  ctjm_out_fifo u_out (
    .clk, .rst_n, .wr(b_valid), .wdata(b_res), .wr_ok(b_ok),
    .rd(out_pop), .rdata(out_item), .empty(out_empty)
  );

  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !fr_valid) else $error("crossing queue overflow");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_ne) else $error("pop from empty crossing queue");
  a_rst: assert property (@(posedge clk) disable iff (!rst_n)
    fr_restart |-> !q_ne && b_idle) else $error("restart while busy");

endmodule

/* hw/rtl/ctjm_front.sv */
// ----------------------------------------------------------------------------
// ctjm_front
// Crossing detector: tracks the phase per sample and emits crossing requests.
// ----------------------------------------------------------------------------
module ctjm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  ctjm_pkg::in_item_t             item,
  input  logic signed [ctjm_pkg::SampleW-1:0] threshold,
  input  logic [ctjm_pkg::PerW-1:0]      period,
  output logic                           req_valid,
  output ctjm_pkg::xreq_t                req,
  output logic                           req_restart
);
  import ctjm_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT_LOW, PH_FIRST_RISE, PH_WAIT_FALL, PH_WAIT_RISE
  } phase_t;

  phase_t                    phase_r, ph;
  logic signed [SampleW-1:0] last_r, last;
  logic [CntW-1:0]           time_r, tcur;
  logic                      high;
  logic signed [NumW-1:0]    s_x, l_x, t_x;

  always_comb begin
    ph   = item.restart ? PH_WAIT_LOW : phase_r;
    last = item.restart ? '0 : last_r;
    tcur = item.restart ? '0 : time_r;
    high = item.sample > threshold;
    s_x  = NumW'(item.sample);
    l_x  = NumW'(last);
    t_x  = NumW'(threshold);
    req_valid  = 1'b0;
    req.kind   = KIND_REF;
    req.num    = NumW'(t_x - l_x);
    req.den    = NumW'(s_x - l_x);
    req.base   = tcur - CntW'(1);
    req.period = period;
    unique case (ph)
      PH_WAIT_LOW:   req_valid = 1'b0;
      PH_FIRST_RISE: req_valid = high;
      PH_WAIT_FALL: begin
        req_valid = !high;
        req.kind  = KIND_FALL;
        req.num   = NumW'(l_x - t_x);
        req.den   = NumW'(l_x - s_x);
      end
      PH_WAIT_RISE: begin
        req_valid = high;
        req.kind  = KIND_RISE;
      end
      default: req_valid = 1'b0;
    endcase
    req_valid   = req_valid & take;
    req_restart = take & item.restart;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_LOW;
      last_r  <= '0;
      time_r  <= '0;
    end else if (take) begin
      last_r <= item.sample;
      time_r <= tcur + CntW'(1);
      unique case (ph)
        PH_WAIT_LOW:   if (!high) phase_r <= PH_FIRST_RISE;
                       else phase_r <= PH_WAIT_LOW;
        PH_FIRST_RISE: if (high) phase_r <= PH_WAIT_FALL;
                       else phase_r <= PH_FIRST_RISE;
        PH_WAIT_FALL:  if (!high) phase_r <= PH_WAIT_RISE;
                       else phase_r <= PH_WAIT_FALL;
        PH_WAIT_RISE:  if (high) phase_r <= PH_WAIT_FALL;
                       else phase_r <= PH_WAIT_RISE;
        default:       phase_r <= PH_WAIT_LOW;
      endcase
    end
  end

endmodule

/* hw/rtl/ctjm_queue.sv */
// ----------------------------------------------------------------------------
// ctjm_queue
// Short request queue between crossing detector and interpolation back end.
// ----------------------------------------------------------------------------
module ctjm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  ctjm_pkg::xreq_t  wdata,
  input  logic             rd,
  output ctjm_pkg::xreq_t  rdata,
  output logic             nonempty,
  output logic             full
);
  import ctjm_pkg::*;

  xreq_t              mem [QueueDepth];
  logic [QueueAw-1:0] wp_r, rp_r;
  logic [QueueAw:0]   cnt_r;

  assign nonempty = cnt_r != '0;
  assign full     = cnt_r == (QueueAw+1)'(QueueDepth);
  assign rdata    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + QueueAw'(1);
      if (rd) rp_r <= rp_r + QueueAw'(1);
      cnt_r <= cnt_r + (QueueAw+1)'(wr) - (QueueAw+1)'(rd);
    end
  end

endmodule

/* hw/rtl/ctjm_back.sv */
// ----------------------------------------------------------------------------
// ctjm_back
// Interpolation divider, TIE arithmetic and peak-to-peak tracking.
// ----------------------------------------------------------------------------
module ctjm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic                 req_valid,
  input  ctjm_pkg::xreq_t      req,
  output logic                 req_pop,
  output logic                 res_valid,
  output ctjm_pkg::out_item_t  res,
  input  logic                 res_ready,
  output logic                 idle
);
  import ctjm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_ERR, ST_PP, ST_OUT
  } state_t;

  localparam int StepW = $clog2(QuoW + 1);

  state_t                  state_r;
  xreq_t                   cur_r;
  logic [QuoW-1:0]         quo_r;
  logic [NumW:0]           rem_r;
  logic [StepW-1:0]        step_r;
  logic [TimeW-1:0]        ref_r, fall_r, rise_r, full_r;
  logic [CntW-1:0]         cnt_r;
  logic signed [TimeW-1:0] nmax_r, nmin_r, pmax_r, pmin_r, ne_r, pe_r;
  logic [NumW:0]           rem_sh, rem_sub;
  logic                    qbit;
  logic [TimeW-1:0]        xtime;
  localparam logic signed [TimeW-1:0] TMin = {1'b1, {(TimeW-1){1'b0}}};
  localparam logic signed [TimeW-1:0] TMax = {1'b0, {(TimeW-1){1'b1}}};

  always_comb begin
    rem_sh  = {rem_r[NumW-1:0], (step_r < StepW'(NumW)) ? quo_r[QuoW-1] : 1'b0};
    rem_sub = rem_sh - {1'b0, cur_r.den};
    qbit    = !rem_sub[NumW];
    xtime   = TimeW'({cur_r.base, FracW'(0)}) + TimeW'(quo_r);
  end

  assign req_pop   = (state_r == ST_IDLE) && req_valid && !clear;
  assign res_valid = state_r == ST_OUT;
  assign idle      = state_r == ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      state_r <= ST_IDLE;
      ref_r <= '0; fall_r <= '0; cnt_r <= '0;
      nmax_r <= TMin; nmin_r <= TMax; pmax_r <= TMin; pmin_r <= TMax;
    end else begin
      unique case (state_r)
        ST_IDLE: if (req_valid) begin
          cur_r   <= req;
          quo_r   <= {req.num, FracW'(0)};
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r  <= qbit ? rem_sub : rem_sh;
          quo_r  <= {quo_r[QuoW-2:0], qbit};
          step_r <= step_r + StepW'(1);
          if (step_r == StepW'(QuoW - 1)) state_r <= ST_MUL;
        end
        ST_MUL: begin
          unique case (cur_r.kind)
            KIND_REF:  begin ref_r <= xtime; state_r <= ST_IDLE; end
            KIND_FALL: begin fall_r <= xtime; state_r <= ST_IDLE; end
            default: begin
              rise_r  <= xtime;
              cnt_r   <= cnt_r + CntW'(1);
              full_r  <= TimeW'((cnt_r + CntW'(1)) * 64'(cur_r.period));
              state_r <= ST_ERR;
            end
          endcase
        end
        ST_ERR: begin
          ne_r <= fall_r - ref_r - (full_r - TimeW'(cur_r.period >> 1));
          pe_r <= rise_r - ref_r - full_r;
          state_r <= ST_PP;
        end
        ST_PP: begin
          if (ne_r > nmax_r) nmax_r <= ne_r;
          if (ne_r < nmin_r) nmin_r <= ne_r;
          if (pe_r > pmax_r) pmax_r <= pe_r;
          if (pe_r < pmin_r) pmin_r <= pe_r;
          state_r <= ST_OUT;
        end
        ST_OUT: if (res_ready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    res.neg_tie      = ne_r;
    res.pos_tie      = pe_r;
    res.neg_pp       = nmax_r - nmin_r;
    res.pos_pp       = pmax_r - pmin_r;
    res.period_index = cnt_r;
  end

endmodule

/* hw/rtl/ctjm_out_fifo.sv */
// ----------------------------------------------------------------------------
// ctjm_out_fifo
// Result queue presented to the consumer.
// ----------------------------------------------------------------------------
module ctjm_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  ctjm_pkg::out_item_t wdata,
  output logic                wr_ok,
  input  logic                rd,
  output ctjm_pkg::out_item_t rdata,
  output logic                empty
);
  import ctjm_pkg::*;

  out_item_t          mem [QueueDepth];
  logic [QueueAw-1:0] wp_r, rp_r;
  logic [QueueAw:0]   cnt_r;
  logic               do_wr, do_rd;

  assign empty = cnt_r == '0;
  assign wr_ok = cnt_r != (QueueAw+1)'(QueueDepth);
  assign do_wr = wr && wr_ok;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + QueueAw'(1);
      if (do_rd) rp_r <= rp_r + QueueAw'(1);
      cnt_r <= cnt_r + (QueueAw+1)'(do_wr) - (QueueAw+1)'(do_rd);
    end
  end

endmodule

/* tb/tb_clock_tie_jitter_meter.sv */
// ----------------------------------------------------------------------------
// tb_clock_tie_jitter_meter
// Self-checking bench for the clock TIE jitter meter.
//
// Sends sampled clock records with random run lengths, levels and noise.
// A cycle-free predictor tracks the crossing state and builds the expected
// TIE and peak-to-peak per completed period. A monitor compares each popped
// result with the oldest expected one. The threshold and period are swept
// through their extremes between idle phases. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_clock_tie_jitter_meter;
  import ctjm_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT_LOW   = 2'd0,
    PH_FIRST_RISE = 2'd1,
    PH_WAIT_FALL  = 2'd2,
    PH_WAIT_RISE  = 2'd3
  } meter_phase_t;

  localparam int DrainCycles = 200;
  localparam int StallLimit  = 20000;
  localparam logic [63:0] TimeMask = (64'd1 << TimeW) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_THRESHOLD;
  logic [PerW-1:0] cfg_data = '0;

  clock_tie_jitter_meter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // configuration and meter state copy
  logic signed [SampleW-1:0] thr_q;
  logic [PerW-1:0] period_q;
  meter_phase_t phase_q;
  logic signed [SampleW-1:0] last_q;
  logic [CntW-1:0] stime_q;
  logic [TimeW-1:0] ref_t_q, fall_t_q;
  logic [CntW-1:0] count_q;
  longint neg_max_q, neg_min_q, pos_max_q, pos_min_q;

  out_item_t tie_expected[$];
  int errors = 0;
  int n_sent = 0;
  int n_results = 0;
  bit no_idle = 1'b0;
  int stall_cnt = 0;

  function automatic longint as_time(logic [63:0] x);
    logic signed [TimeW-1:0] v;
    v = x[TimeW-1:0];
    return longint'(v);
  endfunction

  function automatic void clear_meter();
    phase_q = PH_WAIT_LOW;
    last_q = '0;
    stime_q = '0;
    ref_t_q = '0;
    fall_t_q = '0;
    count_q = '0;
    neg_max_q = -(longint'(1) << (TimeW - 1));
    pos_max_q = neg_max_q;
    neg_min_q = (longint'(1) << (TimeW - 1)) - 1;
    pos_min_q = neg_min_q;
  endfunction

  function automatic logic [TimeW-1:0] cross_time(longint num, longint den);
    logic [63:0] frac;
    logic [CntW-1:0] base;
    frac = (64'(num) << FracW) / 64'(den);
    base = stime_q - 1;
    return TimeW'(((64'(base) << FracW) + frac) & TimeMask);
  endfunction

  function automatic void predict_tie(logic signed [SampleW-1:0] s, logic r);
    longint th, ls;
    logic [TimeW-1:0] rise;
    logic [63:0] full, nerr, perr;
    longint ne, pe;
    out_item_t res;
    if (r) clear_meter();
    th = longint'(thr_q);
    ls = longint'(last_q);
    case (phase_q)
      PH_WAIT_LOW: if (s <= thr_q) phase_q = PH_FIRST_RISE;
      PH_FIRST_RISE: if (s > thr_q) begin
        ref_t_q = cross_time(th - ls, longint'(s) - ls);
        phase_q = PH_WAIT_FALL;
      end
      PH_WAIT_FALL: if (s <= thr_q) begin
        fall_t_q = cross_time(ls - th, ls - longint'(s));
        phase_q = PH_WAIT_RISE;
      end
      default: if (s > thr_q) begin
        rise = cross_time(th - ls, longint'(s) - ls);
        count_q = count_q + 1;
        full = 64'(count_q) * 64'(period_q);
        nerr = 64'(fall_t_q) - 64'(ref_t_q) - (full - 64'(period_q >> 1));
        perr = 64'(rise) - 64'(ref_t_q) - full;
        ne = as_time(nerr);
        pe = as_time(perr);
        if (ne > neg_max_q) neg_max_q = ne;
        if (ne < neg_min_q) neg_min_q = ne;
        if (pe > pos_max_q) pos_max_q = pe;
        if (pe < pos_min_q) pos_min_q = pe;
        res.neg_tie = nerr[TimeW-1:0];
        res.pos_tie = perr[TimeW-1:0];
        res.neg_pp = TimeW'(64'(neg_max_q - neg_min_q) & TimeMask);
        res.pos_pp = TimeW'(64'(pos_max_q - pos_min_q) & TimeMask);
        res.period_index = count_q;
        tie_expected.push_back(res);
        phase_q = PH_WAIT_FALL;
      end
    endcase
    last_q = s;
    stime_q = stime_q + 1;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s at period %0d: got %h want %h", field,
             out_item.period_index, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_pop && !out_empty) begin
      n_results++;
      if (tie_expected.size() == 0) begin
        $display("unexpected result, period %0d", out_item.period_index);
        errors++;
      end else begin
        w = tie_expected.pop_front();
        if (out_item.neg_tie !== w.neg_tie) report_mismatch("neg_tie", out_item.neg_tie, w.neg_tie);
        if (out_item.pos_tie !== w.pos_tie) report_mismatch("pos_tie", out_item.pos_tie, w.pos_tie);
        if (out_item.neg_pp !== w.neg_pp) report_mismatch("neg_pp", out_item.neg_pp, w.neg_pp);
        if (out_item.pos_pp !== w.pos_pp) report_mismatch("pos_pp", out_item.pos_pp, w.pos_pp);
        if (out_item.period_index !== w.period_index)
          report_mismatch("period_index", out_item.period_index, w.period_index);
      end
    end
  end

  always @(negedge clk) out_pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);

  // watchdog
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // hold push for a following request; drop it when the sender idles
  task automatic send_sample(logic signed [SampleW-1:0] s, logic r);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 12) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= '{sample: s, restart: r};
    do @(posedge clk); while (in_full);
    predict_tie(s, r);
    n_sent++;
  endtask

  task automatic write_reg(logic idx, logic [PerW-1:0] data);
    @(negedge clk);
    in_push <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_THRESHOLD) thr_q = data[SampleW-1:0];
    else period_q = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (tie_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic signed [SampleW-1:0] level(bit hi);
    int t;
    t = int'(thr_q);
    if (hi) return (t == 32767) ? 16'sd32767 : SampleW'($urandom_range(32767 - t - 1) + t + 1);
    return SampleW'(t - int'($urandom_range(t + 32768)));
  endfunction

  // one clock record: restart, then alternating low and high runs
  task automatic send_record(int halves);
    send_sample(level($urandom_range(1)), 1'b1);
    for (int h = 0; h < halves; h++)
      repeat ($urandom_range(1, 6)) send_sample(level(h[0]), 1'b0);
  endtask

  task automatic test_directed();
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd3, 1'b0);
    wait_drain();
    write_reg(CFG_THRESHOLD, 32'h0000_8000);
    write_reg(CFG_PERIOD, 32'h0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32767, 1'b0);
    wait_drain();
    write_reg(CFG_THRESHOLD, 32'h0000_7fff);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
  endtask

  task automatic test_config_sweep();
    logic [15:0] thr_set[6] = '{16'h0000, 16'h8000, 16'h7ffe, 16'h8001, 16'h1234, 16'hff00};
    logic [31:0] per_set[6] = '{32'h0, 32'hffff_ffff, 32'h0000_0001, 32'h0005_8000,
                                32'h0003_0000, 32'h0002_0000};
    for (int k = 0; k < 6; k++) begin
      wait_drain();
      write_reg(CFG_THRESHOLD, {16'h0, thr_set[k]});
      write_reg(CFG_PERIOD, per_set[k]);
      repeat (3) send_record($urandom_range(4, 14));
    end
  endtask

  task automatic test_random_records();
    wait_drain();
    write_reg(CFG_THRESHOLD, $urandom_range(65535));
    write_reg(CFG_PERIOD, $urandom);
    while (n_sent < 1100) begin
      if ($urandom_range(99) < 85) send_record($urandom_range(2, 20));
      else repeat ($urandom_range(1, 15)) send_sample(SampleW'($urandom), $urandom_range(15) == 0);
    end
  endtask

  task automatic test_drain_pause();
    send_record(8);
    wait_drain();
    send_record(8);
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    repeat (6) send_record($urandom_range(6, 16));
    no_idle = 1'b0;
  endtask

  initial begin
    thr_q = '0;
    period_q = 32'd655360;
    clear_meter();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_sweep();
    test_drain_pause();
    test_no_idle();
    test_random_records();
    wait_drain();
    if (errors == 0 && tie_expected.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
